@@ design/rdpt_pkg.sv @@
`default_nettype none

package rdpt_pkg;

    // one hundred years of seconds
    localparam logic [31:0]        CENTURY_SECS   = 32'd3155760000;
    localparam logic signed [34:0] CENTURY_SECS_S = 35'sd3155760000;
    localparam logic signed [34:0] DAY_SECS_S     = 35'sd86400;

    // floor(x / 1000) for x below 2**20 as (x * POLL_RECIP) >> POLL_SHIFT
    localparam int                 POLL_SHIFT = 30;
    localparam logic [20:0]        POLL_RECIP = 21'd1073742;

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_CHECK   = 2'd1,
        MODE_SET     = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    // one item after the intake stage, seconds already worked out
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] date_secs;
        logic [10:0] poll_secs;
        logic [31:0] set_secs;
        logic        restart_too;
    } item_t;

    typedef struct packed {
        logic [31:0] current_secs;
        logic [31:0] start_secs;
    } core_status_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // valid for -C < x < 2C
    function automatic logic [31:0] mod_century(input logic signed [34:0] x);
        logic signed [34:0] r;
        if (x < 0)
        begin
            r = x + CENTURY_SECS_S;
        end
        else if (x >= CENTURY_SECS_S)
        begin
            r = x - CENTURY_SECS_S;
        end
        else
        begin
            r = x;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] reduce_word(input logic [31:0] x);
        logic [31:0] r;
        if (x >= CENTURY_SECS)
        begin
            r = x - CENTURY_SECS;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/rdpt_conv.sv @@
`default_nettype none

module rdpt_conv (
    input  wire logic [1:0]                  mode,
    input  wire logic [rdpt_pkg::IN_DATA_W-1:0] data,
    output rdpt_pkg::item_t                  item
);
    import rdpt_pkg::*;

    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] millis;
    logic [31:0] set_value;

    logic [3:0]  month_c;
    logic [15:0] days;
    logic        leap_add;
    logic [32:0] day_secs;
    logic [16:0] hms;
    logic signed [34:0] total;
    logic [40:0] poll_prod;

    assign year      = data[6:0];
    assign month     = data[10:7];
    assign day       = data[15:11];
    assign hour      = data[20:16];
    assign minute    = data[26:21];
    assign second    = data[32:27];
    assign millis    = data[52:33];
    assign set_value = data[84:53];

    always_comb
    begin
        if (month == 4'd0)
        begin
            month_c = 4'd1;
        end
        else if (month > 4'd12)
        begin
            month_c = 4'd12;
        end
        else
        begin
            month_c = month;
        end
    end

    // year 00 counts as leap, so leap days before year y is (y + 3) / 4
    assign leap_add = (month_c > 4'd2) && (year[1:0] == 2'b00);
    assign days = {9'b0, year} * 16'd365
                + 16'({1'b0, year} + 8'd3 >> 2)
                + 16'(days_before_month(month_c - 4'd1))
                + 16'(leap_add)
                + 16'(day);

    assign day_secs = {17'b0, days} * 33'd86400;
    assign hms      = {12'b0, hour} * 17'd3600 + {11'b0, minute} * 17'd60 + 17'(second);
    // day field counts from one; day zero lands one day back
    assign total    = $signed({2'b0, day_secs}) + $signed({18'b0, hms}) - DAY_SECS_S;

    assign poll_prod = {21'b0, millis} * {20'b0, POLL_RECIP};

    assign item.mode        = mode;
    assign item.date_secs   = mod_century(total);
    assign item.poll_secs   = poll_prod[POLL_SHIFT+10:POLL_SHIFT];
    assign item.set_secs    = reduce_word(set_value);
    assign item.restart_too = data[85];

endmodule

`default_nettype wire

@@ design/rdpt_core.sv @@
`default_nettype none

module rdpt_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire rdpt_pkg::item_t      item,
    input  wire logic [31:0]          period,
    output logic [31:0]               elapsed,
    output logic                      ready_res,
    output rdpt_pkg::core_status_t    status
);
    import rdpt_pkg::*;

    logic [31:0] current_reg, current_next;
    logic [31:0] start_reg, start_next;
    logic        init_reg, init_next;

    logic [31:0] add_b;
    logic [31:0] sub_c;
    logic [31:0] el_raw;
    logic [31:0] set_start;
    logic        take_poll;

    // one shared modular adder: poll + b - c
    assign el_raw    = mod_century($signed({3'b0, add_b}) + $signed({24'b0, item.poll_secs})
                                   - $signed({3'b0, sub_c}));
    assign set_start = mod_century($signed({3'b0, current_reg}) - $signed({3'b0, item.set_secs}));

    always_comb
    begin
        current_next = current_reg;
        start_next   = start_reg;
        init_next    = init_reg;
        add_b        = current_reg;
        sub_c        = start_reg;
        take_poll    = 1'b0;
        ready_res    = 1'b0;
        case (mode_t'(item.mode))
            MODE_SAMPLE:
            begin
                current_next = item.date_secs;
                add_b        = item.date_secs;
                if (!init_reg)
                begin
                    init_next  = 1'b1;
                    start_next = item.date_secs;
                    take_poll  = 1'b1;
                end
            end
            MODE_CHECK:
            begin
                if (el_raw >= period)
                begin
                    ready_res  = 1'b1;
                    start_next = current_reg;
                    take_poll  = 1'b1;
                end
            end
            MODE_SET:
            begin
                // without restart_too, elapsed after the set is poll + set value
                add_b = item.set_secs;
                sub_c = 32'd0;
                if (item.restart_too)
                begin
                    start_next = current_reg;
                    take_poll  = 1'b1;
                end
                else
                begin
                    start_next = set_start;
                end
            end
            default:
            begin
                start_next = current_reg;
                take_poll  = 1'b1;
            end
        endcase
    end

    // after a restart, start equals current and only the poll seconds remain
    assign elapsed = take_poll ? {21'b0, item.poll_secs} : el_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= '0;
            start_reg   <= '0;
            init_reg    <= 1'b0;
        end
        else if (fire)
        begin
            current_reg <= current_next;
            start_reg   <= start_next;
            init_reg    <= init_next;
        end
    end

    assign status.current_secs = current_reg;
    assign status.start_secs   = start_reg;

endmodule

`default_nettype wire

@@ design/rtc_date_period_timer_top.sv @@
// Periodic timer fed by RTC date samples.
// Input stream (s_*): tuser carries the item kind (sample, check, set, restart),
// tdata the date fields, milliseconds since poll, set value and restart flag.
// Output stream (m_*): one transfer per input item, in order, carrying the
// elapsed seconds after the item and the ready flag of a check.
// Config channel (cfg_*): writes the period in seconds; always ready, reduced
// modulo one hundred years on the write. Write only while the block is idle.
// Pipeline: each item passes the intake register, then the result register,
// before it is offered on m_tvalid. Throughput: one item per cycle while m_tready
// stays high; the date conversion feeds the intake register and the timer
// update feeds the result register.
// Reset: period, current time, start time and the first-sample flag clear;
// both stages empty.
// Stall: with m_tready low the result register holds; the intake register
// still takes one more item, then s_tready drops until the result moves on.
`default_nettype none

module rtc_date_period_timer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // tuser: mode[1:0]
    // tdata: year[6:0] month[10:7] day[15:11] hour[20:16] minute[26:21]
    //        second[32:27] millis_since_poll[52:33] set_value[84:53]
    //        restart_too[85], zero pad [87:86]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rdpt_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic [rdpt_pkg::IN_USER_W-1:0]   s_tuser,
    // tdata: elapsed[31:0] ready_res[32], zero pad [39:33]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [rdpt_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [31:0]                      cfg_data
);
    import rdpt_pkg::*;

    item_t        conv_item;
    item_t        s1_item_reg;
    logic         s1_valid_reg, s1_valid_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  out_elapsed_reg;
    logic         out_ready_reg;
    logic [31:0]  period_reg;

    logic         in_xfer;
    logic         s2_free;
    logic         fire;
    logic [31:0]  core_elapsed;
    logic         core_ready;
    core_status_t core_st;

    rdpt_conv u_conv (
        .mode (s_tuser),
        .data (s_tdata),
        .item (conv_item)
    );

    rdpt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item_reg),
        .period    (period_reg),
        .elapsed   (core_elapsed),
        .ready_res (core_ready),
        .status    (core_st)
    );

    assign s2_free  = !out_valid_reg || m_tready;
    assign fire     = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s2_free;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= reduce_word(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg <= conv_item;
        end
        if (fire)
        begin
            out_elapsed_reg <= core_elapsed;
            out_ready_reg   <= core_ready;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_ready_reg, out_elapsed_reg};

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        (core_st.current_secs < CENTURY_SECS) && (core_st.start_secs < CENTURY_SECS))
        else $error("timer state out of range");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg < CENTURY_SECS)
        else $error("period not reduced");

    a_elapsed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_elapsed_reg < CENTURY_SECS))
        else $error("elapsed out of range");

    // a check that fires restarts, leaving only the poll seconds
    a_fired_small: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_ready_reg) |-> (out_elapsed_reg <= 32'd1048))
        else $error("fired check reports stale elapsed");

    a_fire_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && core_ready) |=> (core_st.start_secs == core_st.current_secs))
        else $error("fired check did not restart");

endmodule

`default_nettype wire
